/* rtl/assert_macros.svh */
// assertion macros included by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/hbs_pkg.sv */
// types, constants and helpers of the heightmap bilinear sampler
`timescale 1ns / 1ps

package hbs_pkg;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // item field widths
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned COORD_W  = 19;
  localparam int unsigned RESULT_W = 20;

  // world to cell mapping
  localparam int unsigned WORLD_OFFSET = 200000;
  localparam int unsigned WORLD_MAX    = 399999;
  localparam int unsigned CELL_SIZE    = 5000;
  localparam int unsigned CELL_W       = 7;   // cell index 0..79
  localparam int unsigned FRAC_W       = 13;  // offset inside a cell 0..4999
  localparam int unsigned WEIGHT_W     = 25;  // product of two offsets
  // x / 5000 == (x * CELL_RECIP) >> CELL_SHIFT, exact for x < 2^19
  localparam longint unsigned CELL_RECIP = 858994;
  localparam int unsigned     CELL_SHIFT = 32;

  // blend: 10 * sum / 25000000 == sum / 2500000 == (|sum| >> 5) / 78125
  localparam int unsigned     PROD_W      = 42;
  localparam int unsigned     BLEND_POW2  = 5;
  localparam int unsigned     MAG_W       = 35;
  localparam int unsigned     QUOT_W      = 19;
  localparam longint unsigned BLEND_ODD   = 78125;
  // estimate is the quotient or one below it, fixed by one compare
  localparam longint unsigned BLEND_RECIP = 439804;
  localparam int unsigned     BLEND_SHIFT = 35;

  // pipeline and result queue
  localparam int unsigned PIPE_STAGES = 10;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QUEUE_AW    = 4;

  // offset a world coordinate into the map and saturate it to 0..WORLD_MAX
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W:0] s;
    logic [COORD_W-1:0]      r;
    s = (COORD_W + 1)'(c) + (COORD_W + 1)'(WORLD_OFFSET);
    if (s[COORD_W]) begin
      r = '0;
    end else if (s[COORD_W-1:0] > COORD_W'(WORLD_MAX)) begin
      r = COORD_W'(WORLD_MAX);
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/heightmap_bilinear_sampler.sv */
// heightmap_bilinear_sampler: top level of the bilinear ground height sampler.
// Takes one item per clock while stall_o is low, load or sample, with no wait between
// items of either kind. A load writes one height sample when it reaches ld3_q; a load index
// at or beyond GRID_POINTS*GRID_POINTS is dropped. A sample item reads its four cell corners
// in a single access to four single-port memory banks split by row and column parity, and
// its result is offered in order with all other sample results. Results wait in a 16-entry
// queue; stall_o rises when 16 sample results are accepted but not yet taken, so a stalled
// output holds off the input side only once that many are outstanding. The memory is not
// cleared at reset: every entry a sample reads must have been loaded first.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module heightmap_bilinear_sampler #(
  parameter int unsigned GRID_POINTS = 81
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [0:0]                          operation_i,
  input  logic [hbs_pkg::INDEX_W-1:0]         load_index_i,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] load_height_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]  query_x_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]  query_z_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [hbs_pkg::RESULT_W-1:0] ground_height_o
);

  localparam int unsigned GW          = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int unsigned MAP_ENTRIES = GRID_POINTS * GRID_POINTS;
  localparam int unsigned HALF        = (GRID_POINTS + 1) / 2;
  localparam int unsigned BANK_DEPTH  = HALF * HALF;
  localparam int unsigned BAW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  // index / GRID_POINTS == (index * LOAD_RECIP) >> LOAD_SHIFT for every 13-bit index
  localparam int unsigned LOAD_SHIFT  = 22;
  localparam longint unsigned LOAD_RECIP =
    ((64'd1 << LOAD_SHIFT) + GRID_POINTS - 1) / GRID_POINTS;
  localparam int unsigned LP_W = hbs_pkg::INDEX_W + LOAD_SHIFT;
  localparam int unsigned XP_W = hbs_pkg::COORD_W + hbs_pkg::CELL_SHIFT + 1;
  localparam int unsigned QW   = hbs_pkg::QUEUE_AW;
  localparam int unsigned NS   = hbs_pkg::PIPE_STAGES;

  // ---------------------------------------------------------------- handshake
  logic          in_acc, in_smp, in_ld, out_acc;
  logic [QW:0]   cnt_q, cnt_d;
  logic [NS-1:0] smp_q;
  logic          ld1_q, ld2_q, ld3_q;

  assign in_acc  = valid_i && !stall_o;
  assign in_smp  = in_acc && (operation_i == hbs_pkg::OP_SAMPLE);
  assign in_ld   = in_acc && (operation_i == hbs_pkg::OP_LOAD);
  assign stall_o = (cnt_q == (QW + 1)'(hbs_pkg::QUEUE_DEPTH));

  // sample items accepted whose result is not yet taken
  assign cnt_d = cnt_q + (QW + 1)'(in_smp) - (QW + 1)'(out_acc);

  // ------------------------------------------------------------- stage 1
  logic [hbs_pkg::INDEX_W-1:0]         idx1_q;
  logic signed [hbs_pkg::HEIGHT_W-1:0] hgt1_q;
  logic [hbs_pkg::COORD_W-1:0]         x1_q, z1_q;

  // ------------------------------------------------------------- stage 2
  logic [hbs_pkg::INDEX_W-1:0]         idx2_q, lq2_d, lq2_q;
  logic signed [hbs_pkg::HEIGHT_W-1:0] hgt2_q;
  logic                                ok2_d;
  logic [hbs_pkg::COORD_W-1:0]         x2_q, z2_q;
  logic [hbs_pkg::CELL_W-1:0]          ix2_d, iz2_d, ix2_q, iz2_q;
  logic [LP_W-1:0]                     lprod;
  logic [XP_W-1:0]                     xprod, zprod;

  always_comb begin
    lprod = LP_W'(idx1_q) * LP_W'(LOAD_RECIP);
    lq2_d = lprod[LP_W-1:LOAD_SHIFT];
    ok2_d = ({4'd0, idx1_q} < 17'(MAP_ENTRIES));
    xprod = XP_W'(x1_q) * XP_W'(hbs_pkg::CELL_RECIP);
    zprod = XP_W'(z1_q) * XP_W'(hbs_pkg::CELL_RECIP);
    ix2_d = xprod[hbs_pkg::CELL_SHIFT +: hbs_pkg::CELL_W];
    iz2_d = zprod[hbs_pkg::CELL_SHIFT +: hbs_pkg::CELL_W];
  end

  // ------------------------------------------------------------- stage 3
  logic [GW-1:0]                       row3_d, col3_d, row3_q, col3_q;
  logic signed [hbs_pkg::HEIGHT_W-1:0] hgt3_q;
  logic [hbs_pkg::CELL_W-1:0]          ix3_q, iz3_q;
  logic [hbs_pkg::FRAC_W-1:0]          fx3_d, fz3_d, fx3_q, fz3_q;
  logic [hbs_pkg::INDEX_W-1:0]         col_full;
  logic [hbs_pkg::COORD_W-1:0]         xbase, zbase;

  always_comb begin
    row3_d   = lq2_q[GW-1:0];
    col_full = idx2_q - hbs_pkg::INDEX_W'(lq2_q * hbs_pkg::INDEX_W'(GRID_POINTS));
    col3_d   = col_full[GW-1:0];
    xbase    = hbs_pkg::COORD_W'(ix2_q) * hbs_pkg::COORD_W'(hbs_pkg::CELL_SIZE);
    zbase    = hbs_pkg::COORD_W'(iz2_q) * hbs_pkg::COORD_W'(hbs_pkg::CELL_SIZE);
    fx3_d    = hbs_pkg::FRAC_W'(x2_q - xbase);
    fz3_d    = hbs_pkg::FRAC_W'(z2_q - zbase);
  end

  // ------------------------------------------ memory access from stage 3
  function automatic logic [BAW-1:0] bank_addr_f(input logic [GW-1:0] row,
                                                 input logic [GW-1:0] col);
    logic [GW-1:0] rh, ch;
    rh = row >> 1;
    ch = col >> 1;
    return BAW'(int'(rh) * int'(HALF) + int'(ch));
  endfunction

  function automatic logic [GW-1:0] corner_f(input logic [hbs_pkg::CELL_W-1:0] c,
                                             input logic                       step);
    logic [7:0] v;
    v = 8'(c) + 8'(step);
    // corners beyond a small grid saturate to its last row or column
    return (v > 8'(GRID_POINTS - 1)) ? GW'(GRID_POINTS - 1) : GW'(v);
  endfunction

  logic [GW-1:0]  cx0, cx1, cz0, cz1;
  logic [3:0]     bank_we;
  logic [BAW-1:0] bank_addr [4];
  logic [1:0]     ld_bank;
  logic [1:0]     sel4_d [4];
  logic [hbs_pkg::FRAC_W-1:0] gx, gz;
  logic [hbs_pkg::WEIGHT_W-1:0] w4_d [4];

  always_comb begin
    cx0 = corner_f(ix3_q, 1'b0);
    cx1 = corner_f(ix3_q, 1'b1);
    cz0 = corner_f(iz3_q, 1'b0);
    cz1 = corner_f(iz3_q, 1'b1);
    ld_bank = {row3_q[0], col3_q[0]};
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = ld3_q && (ld_bank == 2'(b));
      if (ld3_q) begin
        bank_addr[b] = bank_addr_f(row3_q, col3_q);
      end else begin
        // each bank serves the corner whose row and column parity it holds
        bank_addr[b] = bank_addr_f((cz0[0] == 1'(b >> 1)) ? cz0 : cz1,
                                   (cx0[0] == 1'(b & 1)) ? cx0 : cx1);
      end
    end
    // corners in blend order: (x0,z0) (x1,z0) (x0,z1) (x1,z1)
    sel4_d[0] = {cz0[0], cx0[0]};
    sel4_d[1] = {cz0[0], cx1[0]};
    sel4_d[2] = {cz1[0], cx0[0]};
    sel4_d[3] = {cz1[0], cx1[0]};
    gx = hbs_pkg::FRAC_W'(hbs_pkg::CELL_SIZE) - fx3_q;
    gz = hbs_pkg::FRAC_W'(hbs_pkg::CELL_SIZE) - fz3_q;
    w4_d[0] = hbs_pkg::WEIGHT_W'(26'(gx) * 26'(gz));
    w4_d[1] = hbs_pkg::WEIGHT_W'(26'(fx3_q) * 26'(gz));
    w4_d[2] = hbs_pkg::WEIGHT_W'(26'(gx) * 26'(fz3_q));
    w4_d[3] = hbs_pkg::WEIGHT_W'(26'(fx3_q) * 26'(fz3_q));
  end

  logic signed [hbs_pkg::HEIGHT_W-1:0] bank_mem [4][BANK_DEPTH];
  logic signed [hbs_pkg::HEIGHT_W-1:0] rd4_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        bank_mem[b][bank_addr[b]] <= hgt3_q;
      end
      rd4_q[b] <= bank_mem[b][bank_addr[b]];
    end
  end

  // ------------------------------------------------------------- stage 4..10
  logic [1:0]                         sel4_q [4];
  logic [hbs_pkg::WEIGHT_W-1:0]       w4_q [4];
  logic [hbs_pkg::PROD_W-1:0]         p5_d [4];
  logic [hbs_pkg::PROD_W-1:0]         p5_q [4];
  logic [hbs_pkg::PROD_W-1:0]         sum6_d, sum6_q, mag7;
  logic [hbs_pkg::MAG_W-1:0]          u7_q, u8_q, u9_q;
  logic                               neg7_q, neg8_q, neg9_q, neg10_q;
  logic [35:0]                        ph8_d, ph8_q;
  logic [36:0]                        pl8_d, pl8_q;
  logic [54:0]                        est9;
  logic [hbs_pkg::QUOT_W-1:0]         qe9_d, qe9_q, q10_d, q10_q;
  logic [35:0]                        rem10;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      p5_d[b] = hbs_pkg::PROD_W'(rd4_q[sel4_q[b]]) * hbs_pkg::PROD_W'(w4_q[b]);
    end
    sum6_d = p5_q[0] + p5_q[1] + p5_q[2] + p5_q[3];
    mag7   = sum6_q[hbs_pkg::PROD_W-1] ? (~sum6_q + 1'b1) : sum6_q;
    ph8_d  = 36'(u7_q[hbs_pkg::MAG_W-1:18]) * 36'(hbs_pkg::BLEND_RECIP);
    pl8_d  = 37'(u7_q[17:0]) * 37'(hbs_pkg::BLEND_RECIP);
    est9   = (55'(ph8_q) << 18) + 55'(pl8_q);
    qe9_d  = est9[hbs_pkg::BLEND_SHIFT +: hbs_pkg::QUOT_W];
    rem10  = 36'(u9_q) - 36'(qe9_q) * 36'(hbs_pkg::BLEND_ODD);
    q10_d  = qe9_q + hbs_pkg::QUOT_W'(rem10 >= 36'(hbs_pkg::BLEND_ODD));
  end

  // ------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    idx1_q <= load_index_i;
    hgt1_q <= load_height_i;
    x1_q   <= hbs_pkg::clamp_coord(query_x_i);
    z1_q   <= hbs_pkg::clamp_coord(query_z_i);

    idx2_q <= idx1_q;
    lq2_q  <= lq2_d;
    hgt2_q <= hgt1_q;
    x2_q   <= x1_q;
    z2_q   <= z1_q;
    ix2_q  <= ix2_d;
    iz2_q  <= iz2_d;

    row3_q <= row3_d;
    col3_q <= col3_d;
    hgt3_q <= hgt2_q;
    ix3_q  <= ix2_q;
    iz3_q  <= iz2_q;
    fx3_q  <= fx3_d;
    fz3_q  <= fz3_d;

    sel4_q <= sel4_d;
    w4_q   <= w4_d;
    p5_q   <= p5_d;
    sum6_q <= sum6_d;

    u7_q   <= mag7[hbs_pkg::BLEND_POW2 +: hbs_pkg::MAG_W];
    neg7_q <= sum6_q[hbs_pkg::PROD_W-1];
    ph8_q  <= ph8_d;
    pl8_q  <= pl8_d;
    u8_q   <= u7_q;
    neg8_q <= neg7_q;
    qe9_q  <= qe9_d;
    u9_q   <= u8_q;
    neg9_q <= neg8_q;
    q10_q  <= q10_d;
    neg10_q <= neg9_q;
  end

  // ------------------------------------------------------------- result queue
  logic [hbs_pkg::RESULT_W-1:0] queue_mem [hbs_pkg::QUEUE_DEPTH];
  logic [QW:0]                  wr_ptr_q, rd_ptr_q, occ;
  logic                         q_we;
  logic [hbs_pkg::RESULT_W-1:0] q_wdata;

  assign q_we    = smp_q[NS-1];
  assign q_wdata = neg10_q ? -hbs_pkg::RESULT_W'(q10_q) : hbs_pkg::RESULT_W'(q10_q);
  assign occ     = wr_ptr_q - rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[wr_ptr_q[QW-1:0]] <= q_wdata;
    end
  end

  assign valid_o         = (occ != '0);
  assign ground_height_o = queue_mem[rd_ptr_q[QW-1:0]];
  assign out_acc         = valid_o && !stall_i;

  // ------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      smp_q    <= '0;
      ld1_q    <= 1'b0;
      ld2_q    <= 1'b0;
      ld3_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      smp_q    <= {smp_q[NS-2:0], in_smp};
      ld1_q    <= in_ld;
      // range check of the load index sits beside idx1_q
      ld2_q    <= ld1_q && ok2_d;
      ld3_q    <= ld2_q;
      wr_ptr_q <= wr_ptr_q + (QW + 1)'(q_we);
      rd_ptr_q <= rd_ptr_q + (QW + 1)'(out_acc);
    end
  end

  // ------------------------------------------------------------- assertions
  `ASSERT_AT(a_credit_balance, clk_i, rst_ni, ($countones(smp_q) + int'(occ)) == int'(cnt_q), "samples in flight and queued do not match the credit count")
  `ASSERT_AT(a_one_bank_write, clk_i, rst_ni, $onehot0(bank_we), "a load wrote more than one bank")
  `ASSERT_NEVER(a_queue_overrun, clk_i, rst_ni, q_we && (occ == (QW + 1)'(hbs_pkg::QUEUE_DEPTH)), "result queue written while full")
  `ASSERT_AT(a_take_releases, clk_i, rst_ni, (out_acc && !in_smp) |=> (cnt_q == $past(cnt_q) - 1'b1), "taken item did not release its credit")

endmodule

/* tb/tb_heightmap_bilinear_sampler.sv */
// self-checking testbench of the heightmap bilinear sampler
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler;

  localparam int GRID         = 81;
  localparam int MAP_ENTRIES  = GRID * GRID;
  localparam int MAP_SHIFT    = 200000;
  localparam int MAP_LIMIT    = 399999;
  localparam int CELL_LEN     = 5000;
  localparam longint BLEND_DEN = 25000000;
  localparam longint HEIGHT_GAIN = 10;

  localparam int TOTAL_ITEMS  = 1500;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam longint LIMIT_NS = 5000000;

  class height_scoreboard;
    logic signed [hbs_pkg::HEIGHT_W-1:0] heights [MAP_ENTRIES];
    bit                                  loaded  [MAP_ENTRIES];
    logic signed [hbs_pkg::RESULT_W-1:0] expected_heights [$];
    int                                  failures;

    // offset into the map and saturate to its extent
    function int world_pos(int q);
      int p;
      p = q + MAP_SHIFT;
      if (p < 0) p = 0;
      if (p > MAP_LIMIT) p = MAP_LIMIT;
      return p;
    endfunction

    function int map_addr(int cx, int cz);
      if (cx > GRID - 1) cx = GRID - 1;
      if (cz > GRID - 1) cz = GRID - 1;
      return cz * GRID + cx;
    endfunction

    function logic signed [hbs_pkg::RESULT_W-1:0] blend_height(
        logic signed [hbs_pkg::COORD_W-1:0] qx,
        logic signed [hbs_pkg::COORD_W-1:0] qz);
      int     px, pz, ix, iz;
      longint fx, fz, gx, gz, a, b, c, d, sum, h;
      px = world_pos(qx);
      pz = world_pos(qz);
      ix = px / CELL_LEN;
      iz = pz / CELL_LEN;
      fx = px % CELL_LEN;
      fz = pz % CELL_LEN;
      gx = CELL_LEN - fx;
      gz = CELL_LEN - fz;
      a = heights[map_addr(ix, iz)];
      b = heights[map_addr(ix + 1, iz)];
      c = heights[map_addr(ix, iz + 1)];
      d = heights[map_addr(ix + 1, iz + 1)];
      sum = HEIGHT_GAIN * (a * gx * gz + b * fx * gz + c * gx * fz + d * fx * fz);
      // signed division truncates toward zero
      h = sum / BLEND_DEN;
      return h[hbs_pkg::RESULT_W-1:0];
    endfunction

    function void note_item(hbs_pkg::op_e op, logic [hbs_pkg::INDEX_W-1:0] idx,
                            logic signed [hbs_pkg::HEIGHT_W-1:0] hgt,
                            logic signed [hbs_pkg::COORD_W-1:0] qx,
                            logic signed [hbs_pkg::COORD_W-1:0] qz);
      if (op == hbs_pkg::OP_LOAD) begin
        // out-of-range loads leave the map alone
        if (idx < MAP_ENTRIES) begin
          heights[idx] = hgt;
          loaded[idx]  = 1'b1;
        end
      end else begin
        expected_heights.push_back(blend_height(qx, qz));
      end
    endfunction

    function void check_height(logic signed [hbs_pkg::RESULT_W-1:0] got);
      logic signed [hbs_pkg::RESULT_W-1:0] want;
      if (expected_heights.size() == 0) begin
        failures++;
        $display("%0t ground_height: expected none, actual %0d", $time, got);
      end else begin
        want = expected_heights.pop_front();
        if (got !== want) begin
          failures++;
          $display("%0t ground_height: expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_heights.size();
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                valid_i;
  logic                                stall_o;
  logic [0:0]                          operation_i;
  logic [hbs_pkg::INDEX_W-1:0]         load_index_i;
  logic signed [hbs_pkg::HEIGHT_W-1:0] load_height_i;
  logic signed [hbs_pkg::COORD_W-1:0]  query_x_i;
  logic signed [hbs_pkg::COORD_W-1:0]  query_z_i;
  logic                                valid_o;
  logic                                stall_i;
  logic signed [hbs_pkg::RESULT_W-1:0] ground_height_o;

  height_scoreboard sb = new();
  int items_sent;
  int burst_left;
  bit no_gaps;
  bit hold_req;

  heightmap_bilinear_sampler #(
    .GRID_POINTS(GRID)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .operation_i    (operation_i),
    .load_index_i   (load_index_i),
    .load_height_i  (load_height_i),
    .query_x_i      (query_x_i),
    .query_z_i      (query_z_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .ground_height_o(ground_height_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: stall rate changes per segment, long hold-off on request
  initial begin : receiver
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(80, 10);
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_height(ground_height_o);
  end

  // bursts of random length, separated by idle gaps of random length that may be zero
  task automatic pace();
    int gap;
    if (burst_left <= 0 && !no_gaps) begin
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(24, 1);
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(hbs_pkg::op_e op, int idx, int hgt, int qx, int qz);
    pace();
    valid_i       <= 1'b1;
    operation_i   <= op;
    load_index_i  <= hbs_pkg::INDEX_W'(idx);
    load_height_i <= hbs_pkg::HEIGHT_W'(hgt);
    query_x_i     <= hbs_pkg::COORD_W'(qx);
    query_z_i     <= hbs_pkg::COORD_W'(qz);
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_item(op, hbs_pkg::INDEX_W'(idx), hbs_pkg::HEIGHT_W'(hgt),
                 hbs_pkg::COORD_W'(qx), hbs_pkg::COORD_W'(qz));
    items_sent++;
  endtask

  function automatic int rand_height();
    case ($urandom_range(7, 0))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($urandom_range(65535, 0)) - 32768;
    endcase
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(MAP_LIMIT, 0)) - MAP_SHIFT;
      // on or next to a cell edge
      6: return CELL_LEN * int'($urandom_range(GRID - 1, 0))
                + ($urandom_range(1, 0) ? CELL_LEN - 1 : 0) - MAP_SHIFT;
      default: return int'($urandom_range(524287, 0)) - 262144;
    endcase
  endfunction

  task automatic load_sample(int idx, int hgt);
    send_item(hbs_pkg::OP_LOAD, idx, hgt, rand_coord(), rand_coord());
  endtask

  // load any unwritten corner of the cell first, then query
  task automatic sample_at(int qx, int qz);
    int ix;
    int iz;
    int addr;
    ix = sb.world_pos(qx) / CELL_LEN;
    iz = sb.world_pos(qz) / CELL_LEN;
    for (int k = 0; k < 4; k++) begin
      addr = sb.map_addr(ix + k % 2, iz + k / 2);
      if (!sb.loaded[addr]) load_sample(addr, rand_height());
    end
    send_item(hbs_pkg::OP_SAMPLE, int'($urandom_range(8191, 0)), rand_height(), qx, qz);
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit pressed;
    bit paused;
    int r;
    pressed = 1'b0;
    paused  = 1'b0;
    items_sent = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    hold_req   = 1'b0;
    rst_ni        <= 1'b0;
    valid_i       <= 1'b0;
    operation_i   <= hbs_pkg::OP_LOAD;
    load_index_i  <= '0;
    load_height_i <= '0;
    query_x_i     <= '0;
    query_z_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lowest cell at full positive height, queried from beyond the map
    load_sample(0, 32767);
    load_sample(1, 32767);
    load_sample(GRID, 32767);
    load_sample(GRID + 1, 32767);
    sample_at(-262144, -262144);
    // highest cell at full negative height, queried from beyond the map
    load_sample(79 * GRID + 79, -32768);
    load_sample(79 * GRID + 80, -32768);
    load_sample(80 * GRID + 79, -32768);
    load_sample(80 * GRID + 80, -32768);
    sample_at(262143, 262143);
    // indexes past the map are dropped
    load_sample(MAP_ENTRIES, 0);
    load_sample(8191, -1);
    // mixed-sign corners in the middle of the map
    load_sample(40 * GRID + 40, 32767);
    load_sample(40 * GRID + 41, -32768);
    load_sample(41 * GRID + 40, 1);
    load_sample(41 * GRID + 41, -1);
    sample_at(2500, 1250);
    // last offset of the first cell, then first offset of the next
    sample_at(-195001, -200000);
    sample_at(-195000, -200000);

    while (items_sent < TOTAL_ITEMS) begin
      if (!pressed && items_sent >= 500) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (60) sample_at(rand_coord(), rand_coord());
        no_gaps  = 1'b0;
      end
      if (!paused && items_sent >= 1000) begin
        paused = 1'b1;
        valid_i <= 1'b0;
        wait_results();
      end
      r = $urandom_range(9, 0);
      if (r < 6) begin
        sample_at(rand_coord(), rand_coord());
      end else if (r < 9) begin
        load_sample($urandom_range(MAP_ENTRIES - 1, 0), rand_height());
      end else begin
        load_sample($urandom_range(8191, MAP_ENTRIES), rand_height());
      end
    end

    valid_i <= 1'b0;
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
